// ===== sv/mbp_pkg.sv =====
package mbp_pkg;

  localparam int unsigned MaxBytes     = 65536;
  localparam int unsigned MaxFieldBits = 32;
  localparam int unsigned CfgW         = 17;
  localparam int unsigned CapReset     = 65536;

  localparam int unsigned AccW  = 7 + MaxFieldBits;
  localparam int unsigned TotW  = $clog2(AccW + 1);
  localparam int unsigned NW    = 6;
  localparam int unsigned MaxOut = AccW / 8;
  localparam int unsigned CntW  = $clog2(MaxOut + 1);
  localparam int unsigned IdxW  = (MaxOut > 1) ? $clog2(MaxOut) : 1;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    OpWrite = 1'b0,
    OpPad   = 1'b1
  } op_e;

  typedef struct packed {
    logic [MaxOut*8-1:0] bytes;
    logic [CntW-1:0]     cnt;
    logic [2:0]          pad;
    logic                ovf;
  } job_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] pad_count;
    logic       overflow;
    logic       last;
  } rslt_t;

endpackage

// ===== sv/mbp_front.sv =====
module mbp_front import mbp_pkg::*; #(
  parameter int unsigned MAX_BYTES = MaxBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            accept_i,
  input  logic            opcode_i,
  input  logic [31:0]     value_i,
  input  logic [NW-1:0]   bit_count_i,
  output job_t            job_o
);

  localparam int unsigned BeW  = $clog2(MAX_BYTES + 1);
  localparam int unsigned CmpW = ((BeW > CfgW) ? BeW : CfgW) + 4;

  logic [CfgW-1:0] cap_q;
  logic [6:0]      partial_q, partial_d;
  logic [2:0]      filled_q, filled_d;
  logic [BeW-1:0]  emitted_q, emitted_d;

  logic [NW-1:0]   n;
  logic [CmpW-1:0] cap_ext, max_ext, lim, pos_end;
  logic [AccW-1:0] mask, acc, shifted;
  logic [TotW-1:0] total;
  logic [2:0]      rem, pad;
  logic [7:0]      pad_byte;

  always_comb begin
    n = (bit_count_i > NW'(MaxFieldBits)) ? NW'(MaxFieldBits) : bit_count_i;
    cap_ext = CmpW'(cap_q);
    max_ext = CmpW'(MAX_BYTES);
    lim = (cap_ext > max_ext) ? max_ext : cap_ext;
    pos_end = (CmpW'(emitted_q) << 3) + CmpW'(filled_q) + CmpW'(n);

    mask = ~({AccW{1'b1}} << n);
    acc = (AccW'(partial_q) << n) | (AccW'(value_i) & mask);
    total = TotW'(filled_q) + TotW'(n);
    rem = total[2:0];
    shifted = acc >> rem;

    pad = 3'(4'd8 - {1'b0, filled_q});
    pad_byte = {1'b0, partial_q} << pad;

    partial_d = partial_q;
    filled_d  = filled_q;
    emitted_d = emitted_q;
    job_o = '0;

    if (op_e'(opcode_i) == OpPad) begin
      if (filled_q == 3'd0) begin
        job_o = '0;
      end else if (CmpW'(emitted_q) >= lim) begin
        job_o.ovf = 1'b1;
      end else begin
        job_o.bytes = (MaxOut*8)'(pad_byte);
        job_o.cnt   = CntW'(1);
        job_o.pad   = pad;
        partial_d   = '0;
        filled_d    = '0;
        emitted_d   = emitted_q + BeW'(1);
      end
    end else if (n == '0) begin
      job_o = '0;
    end else if (pos_end > (lim << 3)) begin
      job_o.ovf = 1'b1;
    end else begin
      job_o.bytes = shifted[MaxOut*8-1:0];
      job_o.cnt   = CntW'(total >> 3);
      partial_d   = acc[6:0] & ~(7'h7F << rem);
      filled_d    = rem;
      emitted_d   = emitted_q + BeW'(total >> 3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CfgW'(CapReset);
      partial_q <= '0;
      filled_q  <= '0;
      emitted_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        partial_q <= partial_d;
        filled_q  <= filled_d;
        emitted_q <= emitted_d;
      end
    end
  end

  a_pad_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (op_e'(opcode_i) == OpPad) |-> job_o.cnt <= CntW'(1))
    else $error("A pad item produced more than one byte.");

endmodule

// ===== sv/mbp_queue.sv =====
module mbp_queue import mbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntQW = $clog2(QDepth + 1);

  job_t             mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntQW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntQW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntQW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntQW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntQW'(QDepth))
    else $error("Job queue holds more entries than its depth.");

endmodule

// ===== sv/mbp_back.sv =====
module mbp_back import mbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  job_t  job_i,
  output logic  q_pop_o,
  input  logic  pop,
  output logic  empty,
  output rslt_t rslt_o
);

  logic [IdxW-1:0] k_q, k_d;
  logic            out_valid_q, out_valid_d;
  rslt_t           out_q, res;
  logic            load, last;
  logic [IdxW-1:0] sel;

  always_comb begin
    last = (job_i.cnt == '0) || (CntW'(k_q) == job_i.cnt - CntW'(1));
    sel  = IdxW'(job_i.cnt - CntW'(1) - CntW'(k_q));
    res  = '0;
    if (job_i.cnt != '0) begin
      res.out_byte   = job_i.bytes[8*sel +: 8];
      res.byte_valid = 1'b1;
    end
    res.pad_count = job_i.pad;
    res.overflow  = job_i.ovf;
    res.last      = last;

    load    = !q_empty_i && (!out_valid_q || pop);
    q_pop_o = load && last;
    k_d     = k_q;
    if (load) begin
      k_d = last ? '0 : k_q + IdxW'(1);
    end
    out_valid_d = load ? 1'b1 : (pop ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty  = !out_valid_q;
  assign rslt_o = out_q;

  a_k_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> k_q == '0)
    else $error("Byte index did not restart after the last result of a job.");

  a_valid_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.byte_valid && out_q.overflow))
    else $error("A result carries a byte and an overflow at once.");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("Job queue popped while empty.");

endmodule

// ===== sv/msb_first_bit_packer.sv =====
// MSB-first bit packer.
// Input side is a queue write port: an item is taken when push is high and
// full is low. A write item (opcode 0) appends the low bit_count bits of
// value, most significant bit first; a pad item (opcode 1) zero-fills the
// open byte and emits it with the number of pad bits added.
// Result side is a queue read port: the oldest result is shown while empty
// is low and is taken when pop is high. Each item gives one to four results;
// the final one has last set. A write or pad that would go past the capacity is
// dropped and reported with overflow.
// The user must write the capacity register (cfg_we_i/cfg_wdata_i) only
// while idle; the block does not enforce this. A pushed item goes into the
// job queue, then the result register. The front takes one item per cycle
// while its two-entry job queue has room; the back emits one result per
// cycle while results are taken, and so the back sets the sustained rate.
// Reset clears the stream state and restores the capacity to 65536 bytes.
// When the receiver stalls, the result register holds, the job queue fills,
// and full is raised until results are taken again.
module msb_first_bit_packer import mbp_pkg::*; #(
  parameter int unsigned MAX_BYTES = MaxBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            push,
  output logic            full,
  input  logic            opcode_i,
  input  logic [31:0]     value_i,
  input  logic [NW-1:0]   bit_count_i,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic [2:0]      pad_count_o,
  output logic            overflow_o,
  output logic            last_o
);

  logic  accept, q_pop, q_empty;
  job_t  job_in, job_head;
  rslt_t rslt;

  assign accept = push && !full;

  mbp_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .bit_count_i(bit_count_i),
    .job_o      (job_in)
  );

  mbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (job_head)
  );

  mbp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .job_i    (job_head),
    .q_pop_o  (q_pop),
    .pop      (pop),
    .empty    (empty),
    .rslt_o   (rslt)
  );

  assign out_byte_o   = rslt.out_byte;
  assign byte_valid_o = rslt.byte_valid;
  assign pad_count_o  = rslt.pad_count;
  assign overflow_o   = rslt.overflow;
  assign last_o       = rslt.last;

endmodule
